// File: rtl/hfte_pkg.sv
package hfte_pkg;

    localparam int DW       = 32;
    localparam int FRAC     = 24;
    localparam int SQ_STEPS = DW / 2;
    localparam int SQ_CW    = $clog2(SQ_STEPS + 1);
    localparam int CFG_AW   = 3;

    localparam logic [CFG_AW-1:0] REG_VAR_INITIAL          = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RATE_DT              = 3'd1;
    localparam logic [CFG_AW-1:0] REG_HALF_DT              = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KAPPA_DT             = 3'd3;
    localparam logic [CFG_AW-1:0] REG_KAPPA_THETA_DT       = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SQRT_DT              = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SIGMA_RHO_SQRT_DT    = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SIGMA_RHOBAR_SQRT_DT = 3'd7;

    typedef logic signed [DW-1:0] t_word;
    typedef logic signed [DW:0]   t_mop;

    typedef struct packed {
        logic [DW+1:0] rem;
        logic [DW-1:0] root;
    } t_sq_step;

    localparam t_word WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic t_word sat_add(t_word a, t_word b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? WORD_MIN : WORD_MAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic t_word sat_neg(t_word a);
        return (a == WORD_MIN) ? WORD_MAX : t_word'(-a);
    endfunction

    // Rounds a magnitude product to nearest, ties away from zero, then applies
    // the sign and saturates. The negative limit is one larger than the positive.
    function automatic t_word q_round(logic [2*DW-1:0] p, logic neg);
        logic [2*DW:0]      sum;
        logic [2*DW-FRAC:0] sh;
        logic [DW:0]        lim;
        logic [DW:0]        mag;
        sum = {1'b0, p} + ((2*DW+1)'(1) << (FRAC - 1));
        sh  = sum[2*DW:FRAC];
        lim = neg ? {2'b01, {(DW-1){1'b0}}} : {2'b00, {(DW-1){1'b1}}};
        if (sh > (2*DW-FRAC+1)'(lim)) begin
            mag = lim;
        end else begin
            mag = sh[DW:0];
        end
        return neg ? t_word'(-mag) : t_word'(mag);
    endfunction

    // One restoring square-root digit: brings in two radicand bits.
    function automatic t_sq_step sq_step(logic [DW+1:0] rem, logic [DW-1:0] root,
                                         logic [1:0] bits);
        logic [DW+1:0] cur;
        logic [DW+1:0] trial;
        t_sq_step      r;
        cur   = {rem[DW-1:0], bits};
        trial = {root, 2'b01};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {root[DW-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {root[DW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: rtl/heston_full_truncation_euler_step_core.sv
// Heston path-pair stepper, full-truncation Euler with an antithetic partner path.
// Each input word is one time step: z1 and z2 in tdata, path_start in tuser and
// path_last in tlast. The output word carries log return and variance of the
// positive and the antithetic path after the step, and tlast echoes path_last.
// All values are signed Q8.24 and saturate. From accept until the core is ready
// again, two square roots in a single root unit (two root bits per cycle)
// dominate, and a single multiplier and a single saturating adder carry the
// remaining products and sums under a small sequencer. The finished word waits
// in an output register, so a new step can be accepted while the previous word
// has not yet been taken.
module heston_full_truncation_euler_step_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hfte_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,   // z1 [31:0], z2 [63:32]
    input  logic                         s_axis_tuser,   // path_start
    input  logic                         s_axis_tlast,   // path_last
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // log_return_pos [31:0], variance_pos [63:32],
    // log_return_neg [95:64], variance_neg [127:96]
    output logic [127:0]                 m_axis_tdata,
    output logic                         m_axis_tlast    // terminal
);

    import hfte_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_PREP    = 5'd1;
    localparam logic [4:0] S_C2      = 5'd2;
    localparam logic [4:0] S_CSUM    = 5'd3;
    localparam logic [4:0] S_HP      = 5'd4;
    localparam logic [4:0] S_KP      = 5'd5;
    localparam logic [4:0] S_HN      = 5'd6;
    localparam logic [4:0] S_KN      = 5'd7;
    localparam logic [4:0] S_VN1     = 5'd8;
    localparam logic [4:0] S_VN2     = 5'd9;
    localparam logic [4:0] S_WAIT_SP = 5'd10;
    localparam logic [4:0] S_SP1     = 5'd11;
    localparam logic [4:0] S_SP2     = 5'd12;
    localparam logic [4:0] S_SP3     = 5'd13;
    localparam logic [4:0] S_SP4     = 5'd14;
    localparam logic [4:0] S_WAIT_SN = 5'd15;
    localparam logic [4:0] S_SN1     = 5'd16;
    localparam logic [4:0] S_SN2     = 5'd17;
    localparam logic [4:0] S_SN3     = 5'd18;
    localparam logic [4:0] S_SN4     = 5'd19;
    localparam logic [4:0] S_DONE    = 5'd20;

    logic [4:0]  r_state;
    logic [4:0]  n_state;

    // Configuration registers.
    logic [30:0] r_var_initial;
    logic [31:0] r_rate_dt;
    logic [30:0] r_half_dt;
    logic [30:0] r_kappa_dt;
    logic [30:0] r_kappa_theta_dt;
    logic [30:0] r_sqrt_dt;
    logic [31:0] r_sigma_rho_sqrt_dt;
    logic [30:0] r_sigma_rhobar_sqrt_dt;

    // Path state.
    t_word r_lr_p;
    t_word r_var_p;
    t_word r_lr_n;
    t_word r_var_n;

    // Per-step working registers.
    logic [31:0] r_z1;
    logic [31:0] r_z2;
    logic        r_last;
    t_word       r_vp_p;
    t_word       r_vp_n;
    t_word       r_c;
    t_word       r_s;
    t_word       r_t;
    t_word       r_u;

    // Shared multiplier.
    logic [2*DW-1:0] r_prod;
    logic            r_prod_neg;
    t_mop            w_ma;
    t_mop            w_mb;
    logic [DW-1:0]   w_mag_a;
    logic [DW-1:0]   w_mag_b;
    t_word           w_q;

    // Shared saturating adder.
    t_word w_add_a;
    t_word w_add_b;
    t_word w_sum;

    // Square-root unit.
    logic [DW+1:0]   r_sq_rem;
    logic [DW-1:0]   r_sq_root;
    logic [2*DW-1:0] r_sq_rad;
    logic [SQ_CW-1:0] r_sq_cnt;
    logic            r_sq_busy;
    logic            w_sq_start;
    t_word           w_sq_in;
    t_sq_step        w_sq1;
    t_sq_step        w_sq2;

    // Output register.
    logic            r_o_valid;
    logic [127:0]    r_o_data;
    logic            r_o_last;
    logic            w_out_load;

    // Operand views.
    t_word w_var_init;
    t_word w_rate;
    t_word w_hdt;
    t_word w_kdt;
    t_word w_ktdt;
    t_word w_sdt;
    t_word w_srs;
    t_word w_srb;
    t_word w_vp_p_now;
    t_mop  w_z1;
    t_mop  w_nz1;
    t_word w_neg_q;

    assign w_var_init = t_word'($signed(r_var_initial));
    assign w_rate     = t_word'($signed(r_rate_dt));
    assign w_hdt      = t_word'($signed(r_half_dt));
    assign w_kdt      = t_word'($signed(r_kappa_dt));
    assign w_ktdt     = t_word'($signed(r_kappa_theta_dt));
    assign w_sdt      = t_word'($signed(r_sqrt_dt));
    assign w_srs      = t_word'($signed(r_sigma_rho_sqrt_dt));
    assign w_srb      = t_word'($signed(r_sigma_rhobar_sqrt_dt));
    assign w_z1       = t_mop'($signed(r_z1));
    assign w_nz1      = -w_z1;
    assign w_vp_p_now = r_var_p[DW-1] ? '0 : r_var_p;
    assign w_q        = q_round(r_prod, r_prod_neg);
    assign w_neg_q    = sat_neg(w_q);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    assign w_out_load = (r_state == S_DONE) && (!r_o_valid || m_axis_tready);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (s_axis_tvalid) n_state = S_PREP;
            S_PREP:    n_state = S_C2;
            S_C2:      n_state = S_CSUM;
            S_CSUM:    n_state = S_HP;
            S_HP:      n_state = S_KP;
            S_KP:      n_state = S_HN;
            S_HN:      n_state = S_KN;
            S_KN:      n_state = S_VN1;
            S_VN1:     n_state = S_VN2;
            S_VN2:     n_state = S_WAIT_SP;
            S_WAIT_SP: if (!r_sq_busy) n_state = S_SP1;
            S_SP1:     n_state = S_SP2;
            S_SP2:     n_state = S_SP3;
            S_SP3:     n_state = S_SP4;
            S_SP4:     n_state = S_WAIT_SN;
            S_WAIT_SN: if (!r_sq_busy) n_state = S_SN1;
            S_SN1:     n_state = S_SN2;
            S_SN2:     n_state = S_SN3;
            S_SN3:     n_state = S_SN4;
            S_SN4:     n_state = S_DONE;
            S_DONE:    if (w_out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Multiplier operand selection; the registered product is consumed in the following state.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_PREP:  begin w_ma = t_mop'(w_srs);  w_mb = w_z1; end
            S_C2:    begin w_ma = t_mop'(w_srb);  w_mb = t_mop'($signed(r_z2)); end
            S_CSUM:  begin w_ma = t_mop'(w_hdt);  w_mb = t_mop'(r_vp_p); end
            S_HP:    begin w_ma = t_mop'(w_kdt);  w_mb = t_mop'(r_vp_p); end
            S_KP:    begin w_ma = t_mop'(w_hdt);  w_mb = t_mop'(r_vp_n); end
            S_HN:    begin w_ma = t_mop'(w_kdt);  w_mb = t_mop'(r_vp_n); end
            S_SP1,
            S_SN1:   begin w_ma = t_mop'(r_s);    w_mb = t_mop'(w_sdt); end
            S_SP2:   begin w_ma = t_mop'(r_s);    w_mb = t_mop'(r_c); end
            S_SN2:   begin w_ma = t_mop'(r_s);    w_mb = t_mop'(sat_neg(r_c)); end
            S_SP3:   begin w_ma = t_mop'(r_t);    w_mb = w_z1; end
            S_SN3:   begin w_ma = t_mop'(r_t);    w_mb = w_nz1; end
            default: begin w_ma = '0;             w_mb = '0; end
        endcase
    end

    assign w_mag_a = w_ma[DW] ? DW'(-w_ma) : DW'(w_ma);
    assign w_mag_b = w_mb[DW] ? DW'(-w_mb) : DW'(w_mb);

    // Adder operand selection; the sum goes back to the register the state names.
    always_comb begin
        w_add_a = '0;
        w_add_b = '0;
        unique case (r_state)
            S_PREP:  begin w_add_a = r_lr_p;  w_add_b = w_rate; end
            S_C2:    begin w_add_a = r_var_p; w_add_b = w_ktdt; end
            S_CSUM:  begin w_add_a = r_t;     w_add_b = w_q; end
            S_HP:    begin w_add_a = r_lr_p;  w_add_b = w_neg_q; end
            S_KP:    begin w_add_a = r_var_p; w_add_b = w_neg_q; end
            S_HN:    begin w_add_a = r_lr_n;  w_add_b = w_rate; end
            S_KN:    begin w_add_a = r_lr_n;  w_add_b = sat_neg(r_t); end
            S_VN1:   begin w_add_a = r_var_n; w_add_b = w_ktdt; end
            S_VN2:   begin w_add_a = r_var_n; w_add_b = sat_neg(r_u); end
            S_SP3:   begin w_add_a = r_var_p; w_add_b = w_q; end
            S_SP4:   begin w_add_a = r_lr_p;  w_add_b = w_q; end
            S_SN3:   begin w_add_a = r_var_n; w_add_b = w_q; end
            S_SN4:   begin w_add_a = r_lr_n;  w_add_b = w_q; end
            default: begin w_add_a = '0;      w_add_b = '0; end
        endcase
    end

    assign w_sum = sat_add(w_add_a, w_add_b);

    // The positive root starts as soon as the step begins; the antithetic root
    // follows once the positive one has been collected.
    assign w_sq_start = (r_state == S_PREP) || ((r_state == S_WAIT_SP) && !r_sq_busy);
    assign w_sq_in    = (r_state == S_PREP) ? w_vp_p_now : r_vp_n;
    assign w_sq1      = sq_step(r_sq_rem, r_sq_root, r_sq_rad[2*DW-1:2*DW-2]);
    assign w_sq2      = sq_step(w_sq1.rem, w_sq1.root, r_sq_rad[2*DW-3:2*DW-4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                <= S_IDLE;
            r_o_valid              <= 1'b0;
            r_sq_busy              <= 1'b0;
            r_sq_cnt               <= '0;
            r_var_initial          <= '0;
            r_rate_dt              <= '0;
            r_half_dt              <= '0;
            r_kappa_dt             <= '0;
            r_kappa_theta_dt       <= '0;
            r_sqrt_dt              <= '0;
            r_sigma_rho_sqrt_dt    <= '0;
            r_sigma_rhobar_sqrt_dt <= '0;
            r_lr_p                 <= '0;
            r_var_p                <= '0;
            r_lr_n                 <= '0;
            r_var_n                <= '0;
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            if (w_sq_start) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= SQ_CW'(SQ_STEPS);
            end else if (r_sq_busy) begin
                r_sq_cnt <= r_sq_cnt - SQ_CW'(1);
                if (r_sq_cnt == SQ_CW'(1)) begin
                    r_sq_busy <= 1'b0;
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_VAR_INITIAL:          r_var_initial          <= i_cfg_data[30:0];
                    REG_RATE_DT:              r_rate_dt              <= i_cfg_data;
                    REG_HALF_DT:              r_half_dt              <= i_cfg_data[30:0];
                    REG_KAPPA_DT:             r_kappa_dt             <= i_cfg_data[30:0];
                    REG_KAPPA_THETA_DT:       r_kappa_theta_dt       <= i_cfg_data[30:0];
                    REG_SQRT_DT:              r_sqrt_dt              <= i_cfg_data[30:0];
                    REG_SIGMA_RHO_SQRT_DT:    r_sigma_rho_sqrt_dt    <= i_cfg_data;
                    REG_SIGMA_RHOBAR_SQRT_DT: r_sigma_rhobar_sqrt_dt <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tuser) begin
                        r_lr_p  <= '0;
                        r_lr_n  <= '0;
                        r_var_p <= w_var_init;
                        r_var_n <= w_var_init;
                    end
                end
                S_PREP, S_HP, S_SP4:          r_lr_p  <= w_sum;
                S_C2, S_KP, S_SP3:            r_var_p <= w_sum;
                S_HN, S_KN, S_SN4:            r_lr_n  <= w_sum;
                S_VN1, S_VN2, S_SN3:          r_var_n <= w_sum;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= w_mag_a * w_mag_b;
        r_prod_neg <= w_ma[DW] ^ w_mb[DW];

        if (w_sq_start) begin
            r_sq_rem  <= '0;
            r_sq_root <= '0;
            r_sq_rad  <= {{(DW-FRAC){1'b0}}, w_sq_in, {FRAC{1'b0}}};
        end else if (r_sq_busy) begin
            r_sq_rem  <= w_sq2.rem;
            r_sq_root <= w_sq2.root;
            r_sq_rad  <= {r_sq_rad[2*DW-5:0], 4'b0000};
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    r_z1   <= s_axis_tdata[31:0];
                    r_z2   <= s_axis_tdata[63:32];
                    r_last <= s_axis_tlast;
                end
            end
            S_PREP: begin
                r_vp_p <= w_vp_p_now;
                r_vp_n <= r_var_n[DW-1] ? '0 : r_var_n;
            end
            S_C2:      r_t <= w_q;
            S_CSUM:    r_c <= w_sum;
            S_HN:      r_t <= w_q;
            S_KN:      r_u <= w_q;
            S_WAIT_SP: if (!r_sq_busy) r_s <= r_sq_root;
            S_SP2:     r_t <= w_q;
            S_WAIT_SN: if (!r_sq_busy) r_s <= r_sq_root;
            S_SN2:     r_t <= w_q;
            default: ;
        endcase

        if (w_out_load) begin
            r_o_data <= {r_var_n, r_lr_n, r_var_p, r_lr_p};
            r_o_last <= r_last;
        end
    end

endmodule

// File: tb/tb_heston_full_truncation_euler_step_core.sv
`timescale 1ns / 1ps

module tb_heston_full_truncation_euler_step_core;
    import hfte_pkg::*;

    localparam int     NUM_REGS    = 8;
    localparam int     QUIET_LIMIT = 3000;
    localparam int     PHASES      = 8;
    localparam int     PHASE_STEPS = 238;
    localparam longint W_MAX       = 64'sd2147483647;
    localparam longint W_MIN       = -64'sd2147483648;
    localparam t_word  ONE         = 32'sh0100_0000;

    typedef struct packed {
        t_word lr_pos;
        t_word var_pos;
        t_word lr_neg;
        t_word var_neg;
        logic  terminal;
    } t_path_pair;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_index;
    logic [31:0]         i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;   // z1 [31:0], z2 [63:32]
    logic                s_axis_tuser;   // path_start
    logic                s_axis_tlast;   // path_last
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // log_return_pos [31:0], variance_pos [63:32],
    // log_return_neg [95:64], variance_neg [127:96]
    logic [127:0]        m_axis_tdata;
    logic                m_axis_tlast;   // terminal

    logic [NUM_REGS-1:0][31:0] reg_copy = '0;
    longint     lr_pos_st  = 0;
    longint     var_pos_st = 0;
    longint     lr_neg_st  = 0;
    longint     var_neg_st = 0;
    t_path_pair path_pair_q[$];
    int         mismatch_count = 0;
    int         burst_left     = 0;
    int         quiet_cycles   = 0;

    heston_full_truncation_euler_step_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------- fixed-point predictor ----------------

    function automatic longint sx31(logic [31:0] x);
        longint r;
        r = $signed(x[30:0]);
        return r;
    endfunction

    function automatic longint sx32(logic [31:0] x);
        longint r;
        r = $signed(x);
        return r;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (s > W_MAX) return W_MAX;
        if (s < W_MIN) return W_MIN;
        return s;
    endfunction

    function automatic longint neg_sat(longint a);
        return (a == W_MIN) ? W_MAX : -a;
    endfunction

    // Magnitude product rounded half away from zero; the negative side may
    // reach one step further than the positive side.
    function automatic longint mul_round(longint a, longint b);
        longint ma, mb, p, lim;
        logic   neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = (ma * mb + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        lim = neg ? W_MAX + 1 : W_MAX;
        if (p > lim) p = lim;
        return neg ? -p : p;
    endfunction

    function automatic longint sqrt_floor(longint v);
        longint rad, root, trial;
        rad  = v <<< FRAC;
        root = 0;
        for (int b = 30; b >= 0; b--) begin
            trial = root | (64'sd1 <<< b);
            if (trial * trial <= rad) root = trial;
        end
        return root;
    endfunction

    task automatic advance_path(inout longint lr, inout longint vr,
                                input longint z, input longint c);
        longint vp, s, acc;
        vp  = (vr > 0) ? vr : 0;
        s   = sqrt_floor(vp);
        acc = add_sat(lr, sx32(reg_copy[REG_RATE_DT]));
        acc = add_sat(acc, neg_sat(mul_round(sx31(reg_copy[REG_HALF_DT]), vp)));
        acc = add_sat(acc, mul_round(mul_round(s, sx31(reg_copy[REG_SQRT_DT])), z));
        lr  = acc;
        acc = add_sat(vr, sx31(reg_copy[REG_KAPPA_THETA_DT]));
        acc = add_sat(acc, neg_sat(mul_round(sx31(reg_copy[REG_KAPPA_DT]), vp)));
        acc = add_sat(acc, mul_round(s, c));
        vr  = acc;
    endtask

    task automatic predict_path_pair(input t_word z1, input t_word z2,
                                     input logic start, input logic last);
        longint     zp, zn, c;
        t_path_pair want;
        zp = z1;
        zn = -zp;   // the antithetic draw is not saturated
        if (start) begin
            lr_pos_st  = 0;
            lr_neg_st  = 0;
            var_pos_st = sx31(reg_copy[REG_VAR_INITIAL]);
            var_neg_st = var_pos_st;
        end
        c = add_sat(mul_round(sx32(reg_copy[REG_SIGMA_RHO_SQRT_DT]), zp),
                    mul_round(sx31(reg_copy[REG_SIGMA_RHOBAR_SQRT_DT]), sx32(z2)));
        advance_path(lr_pos_st, var_pos_st, zp, c);
        advance_path(lr_neg_st, var_neg_st, zn, neg_sat(c));
        want.lr_pos   = lr_pos_st[31:0];
        want.var_pos  = var_pos_st[31:0];
        want.lr_neg   = lr_neg_st[31:0];
        want.var_neg  = var_neg_st[31:0];
        want.terminal = last;
        path_pair_q.push_back(want);
    endtask

    // ---------------- drivers ----------------

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (path_pair_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] v0, input logic [31:0] rate,
                             input logic [31:0] half, input logic [31:0] kap,
                             input logic [31:0] kth, input logic [31:0] sq,
                             input logic [31:0] srho, input logic [31:0] srhobar);
        wait_idle();
        reg_copy[REG_VAR_INITIAL]          = v0;
        reg_copy[REG_RATE_DT]              = rate;
        reg_copy[REG_HALF_DT]              = half;
        reg_copy[REG_KAPPA_DT]             = kap;
        reg_copy[REG_KAPPA_THETA_DT]       = kth;
        reg_copy[REG_SQRT_DT]              = sq;
        reg_copy[REG_SIGMA_RHO_SQRT_DT]    = srho;
        reg_copy[REG_SIGMA_RHOBAR_SQRT_DT] = srhobar;
        for (int r = 0; r < NUM_REGS; r++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r[CFG_AW-1:0];
            i_cfg_data  <= reg_copy[r];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Words go out in bursts; valid is left high after an accept so that the
    // next word of a burst follows without a bubble.
    task automatic send_step(input t_word z1, input t_word z2,
                             input logic start, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 45);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z2, z1};
        s_axis_tuser  <= start;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_path_pair(z1, z2, start, last);
    endtask

    function automatic t_word draw_normal();
        int    pick;
        t_word z;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            z = pick[0] ? WORD_MAX : WORD_MIN;
        end else if (pick < 13) begin
            z = $urandom;
        end else begin
            // roughly within four standard deviations
            z = $urandom_range(0, 32'h0800_0000);
            z = z - 32'sh0400_0000;
        end
        return z;
    endfunction

    // ---------------- receiver and checks ----------------

    initial begin : out_stall
        int run;
        int stall_pct;
        m_axis_tready = 1'b0;
        forever begin
            stall_pct = $urandom_range(0, 2) * 45;
            run       = $urandom_range(20, 300);
            repeat (run) begin
                @(negedge i_clk);
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_output
        t_path_pair want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (path_pair_q.size() == 0) begin
                $error("output word with no step pending");
                mismatch_count++;
            end else begin
                want = path_pair_q.pop_front();
                check_field("log_return_pos", want.lr_pos, m_axis_tdata[31:0]);
                check_field("variance_pos", want.var_pos, m_axis_tdata[63:32]);
                check_field("log_return_neg", want.lr_neg, m_axis_tdata[95:64]);
                check_field("variance_neg", want.var_neg, m_axis_tdata[127:96]);
                check_field("terminal", want.terminal, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // All registers still at their reset value of zero.
    task automatic test_unconfigured();
        send_step(WORD_MAX, WORD_MIN, 1'b1, 1'b0);
        send_step(WORD_MIN, WORD_MAX, 1'b0, 1'b0);
        send_step('0, '0, 1'b0, 1'b1);
    endtask

    task automatic test_field_extremes();
        load_regs(32'h000A_3D71, 32'd3355, 32'd33288, 32'd133152,
                  32'd5326, 32'd1056846, -32'sd184948, 32'd188727);
        send_step(ONE, '0, 1'b1, 1'b0);
        send_step(-ONE, ONE, 1'b0, 1'b0);
        send_step(WORD_MAX, WORD_MAX, 1'b0, 1'b0);
        send_step(WORD_MIN, WORD_MIN, 1'b0, 1'b0);
        send_step(WORD_MAX, WORD_MIN, 1'b0, 1'b0);
        send_step(WORD_MIN, WORD_MAX, 1'b0, 1'b0);
        send_step('0, '0, 1'b0, 1'b0);
        send_step(-32'sd1, 32'sd1, 1'b0, 1'b1);
        send_step(32'sd1, -32'sd1, 1'b1, 1'b1);
    endtask

    // Strong vol-of-vol drives one path's variance below zero; the initial
    // variance of all ones reads as a negative value in 31 bits.
    task automatic test_negative_variance();
        load_regs(32'h7FFF_FFFF, 32'd1000, 32'h0080_0000, 32'h0080_0000,
                  32'h0000_1000, 32'h0100_0000, 32'h0200_0000, ONE);
        send_step(2 * ONE, ONE, 1'b1, 1'b0);
        send_step(2 * ONE, 2 * ONE, 1'b0, 1'b0);
        send_step(-3 * ONE, ONE, 1'b0, 1'b0);
        send_step(ONE, -2 * ONE, 1'b0, 1'b1);
        send_step(-2 * ONE, -ONE, 1'b0, 1'b0);
        send_step(3 * ONE, 3 * ONE, 1'b0, 1'b1);
    endtask

    task automatic test_saturation();
        load_regs(32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF,
                  32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF);
        send_step(WORD_MAX, WORD_MAX, 1'b1, 1'b0);
        send_step(WORD_MIN, WORD_MIN, 1'b0, 1'b0);
        send_step(WORD_MIN, WORD_MAX, 1'b1, 1'b0);
        send_step(ONE, -ONE, 1'b0, 1'b0);
        send_step(WORD_MAX, WORD_MIN, 1'b0, 1'b1);
        // Bits above each register's width are ignored.
        load_regs(32'h4000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_step(WORD_MIN, WORD_MAX, 1'b1, 1'b0);
        send_step(WORD_MAX, -ONE, 1'b0, 1'b1);
    endtask

    // Mostly well-formed paths with random length; now and then a start or a
    // last flag is flipped to break a path.
    task automatic test_random_paths();
        int   sent;
        int   len;
        logic start;
        logic last;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase % 4 == 3) begin
                load_regs($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            end else begin
                load_regs($urandom_range(0, 32'h0080_0000),
                          $urandom_range(0, 4000) - 1000,
                          $urandom_range(0, 32'h0002_0000),
                          $urandom_range(0, 32'h0010_0000),
                          $urandom_range(0, 32'h0002_0000),
                          $urandom_range(32'h0002_0000, 32'h0040_0000),
                          $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                          $urandom_range(0, 32'h0010_0000));
            end
            sent = 0;
            while (sent < PHASE_STEPS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                  : $urandom_range(1, 40);
                for (int k = 0; k < len; k++) begin
                    start = (k == 0);
                    last  = (k == len - 1);
                    if ($urandom_range(0, 24) == 0) start = ~start;
                    if ($urandom_range(0, 24) == 0) last = ~last;
                    send_step(draw_normal(), draw_normal(), start, last);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unconfigured();
        test_field_extremes();
        test_negative_variance();
        test_saturation();
        test_random_paths();

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && path_pair_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/hfte_pkg.sv
rtl/heston_full_truncation_euler_step_core.sv
tb/tb_heston_full_truncation_euler_step_core.sv
